// ----- design/vrra_pkg.sv -----
package vrra_pkg;

    // Defaults for the top-level parameters
    localparam int TEXT_BYTES_DEF = 4096;
    localparam int LINE_SLOTS_DEF = 256;

    // Field and register widths
    localparam int TS_W      = 13;
    localparam int ML_W      = 9;
    localparam int LEN_W     = 13;
    localparam int IDX_W     = 8;
    localparam int OFF_W     = 12;
    localparam int EVC_W     = 9;
    localparam int CNT_W     = 9;
    localparam int STAT_W    = 2;
    localparam int CFG_IDX_W = 1;
    localparam int CFG_W     = 13;

    // Register values after reset (before clamping)
    localparam int TS_RESET = 4096;
    localparam int ML_RESET = 256;

    // Largest values the register fields can carry
    localparam int TS_FIELD_MAX = (1 << TS_W) - 1;
    localparam int ML_FIELD_MAX = (1 << ML_W) - 1;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_TEXT_SIZE = 1'b0,
        CFG_MAX_LINES = 1'b1
    } cfg_index_t;

    typedef enum logic [STAT_W-1:0] {
        ST_OK        = 2'd0,
        ST_TOO_LONG  = 2'd1,
        ST_NO_RECORD = 2'd2
    } status_t;

    typedef enum logic {
        KIND_ADD  = 1'b0,
        KIND_READ = 1'b1
    } kind_t;

    typedef enum logic [2:0] {
        S_IDLE,
        S_START,
        S_ROOM1,
        S_GAP,
        S_ROOM2,
        S_PLACE,
        S_EVUPD,
        S_RDDATA
    } state_t;

endpackage

// ----- design/vrra_ram.sv -----
module vrra_ram #(
    parameter int WIDTH = 12,
    parameter int DEPTH = 256,
    parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             clk,
    input  logic             we,
    input  logic [AW-1:0]    waddr,
    input  logic [WIDTH-1:0] wdata,
    input  logic             re,
    input  logic [AW-1:0]    raddr,
    output logic [WIDTH-1:0] rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    // One write port, one registered read port; rdata holds between reads
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata <= mem[raddr];
        end
    end

endmodule

// ----- design/variable_record_ring_allocator_unit.sv -----
// Channel  | Handshake           | Payload
// ---------+---------------------+----------------------------------------------
// cfg      | cfg_we              | cfg_index, cfg_data
// in       | in_valid / in_ready | kind, record_length, line_index
// out      | out_valid/out_ready | status, offset, evicted, line_count
//
// One request at a time. An add evicts the oldest records while the ring is full or the
// record does not fit, counts a tail gap too short for it as used, and places it at the
// head; a read fetches the offset of a record by age; a rejected add or missing record gets an error status.
// The sequencer walks the offset ring through one RAM read port per eviction.
// A finished result waits in the output register; the sequencer stalls only when
// that register is still full. Reset is asynchronous and clears the store.
module variable_record_ring_allocator_unit #(
    parameter int TEXT_BYTES = vrra_pkg::TEXT_BYTES_DEF,
    parameter int LINE_SLOTS = vrra_pkg::LINE_SLOTS_DEF
) (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           cfg_we,
    input  logic [vrra_pkg::CFG_IDX_W-1:0] cfg_index,
    input  logic [vrra_pkg::CFG_W-1:0]     cfg_data,
    input  logic                           in_valid,
    output logic                           in_ready,
    input  logic                           kind,
    input  logic [vrra_pkg::LEN_W-1:0]     record_length,
    input  logic [vrra_pkg::IDX_W-1:0]     line_index,
    output logic                           out_valid,
    input  logic                           out_ready,
    output logic [vrra_pkg::STAT_W-1:0]    status,
    output logic [vrra_pkg::OFF_W-1:0]     offset,
    output logic [vrra_pkg::EVC_W-1:0]     evicted,
    output logic [vrra_pkg::CNT_W-1:0]     line_count
);

    import vrra_pkg::*;

    // Effective limits and widths
    localparam int TS_MAX = (TEXT_BYTES < TS_FIELD_MAX) ? TEXT_BYTES : TS_FIELD_MAX;
    localparam int TS_RST = (TS_RESET < TEXT_BYTES) ? TS_RESET : TEXT_BYTES;
    localparam int SLOTS  = (LINE_SLOTS < ML_FIELD_MAX) ? LINE_SLOTS : ML_FIELD_MAX;
    localparam int ML_RST = (ML_RESET < LINE_SLOTS) ? ML_RESET : LINE_SLOTS;
    localparam int AW     = (SLOTS > 1) ? $clog2(SLOTS) : 1;
    localparam int OW     = (TS_MAX > 1) ? $clog2(TS_MAX) : 1;
    localparam int SW     = ML_W + 1;
    localparam int HW     = TS_W + 1;

    // Control state
    state_t            state_reg, state_next;
    state_t            ret_reg, ret_next;
    logic [TS_W-1:0]   ts_reg, ts_next;
    logic [ML_W-1:0]   ml_reg, ml_next;
    logic [AW-1:0]     oldest_reg, oldest_next;
    logic [CNT_W-1:0]  count_reg, count_next;
    logic [TS_W-1:0]   free_reg, free_next;
    logic [OW-1:0]     ooff_reg, ooff_next;
    logic              out_valid_reg, out_valid_next;

    // Working and result payload
    logic [OW-1:0]     head_reg, head_next;
    kind_t             kind_reg, kind_next;
    logic [LEN_W-1:0]  len_reg, len_next;
    logic [IDX_W-1:0]  idx_reg, idx_next;
    logic [EVC_W-1:0]  evc_reg, evc_next;
    status_t           status_reg, status_next;
    logic [OFF_W-1:0]  offset_reg, offset_next;
    logic [EVC_W-1:0]  evicted_reg, evicted_next;
    logic [CNT_W-1:0]  lcount_reg, lcount_next;

    // Offset ring
    logic              ram_we, ram_re;
    logic [AW-1:0]     ram_waddr, ram_raddr;
    logic [OW-1:0]     ram_wdata, ram_rdata;

    // Shared arithmetic
    logic [TS_W-1:0]   head_used;
    logic [HW-1:0]     head_sum;
    logic [OW-1:0]     head_c;
    logic              need_room;
    logic              out_free;
    logic [AW:0]       oldest_inc;
    logic [AW-1:0]     oldest_wrap;
    logic [SW-1:0]     rd_sum, pl_sum;
    logic [AW-1:0]     rd_slot, pl_slot;
    logic [TS_W-1:0]   ev_add;
    logic [HW-1:0]     ev_sum;
    logic [TS_W-1:0]   ts_wr;
    logic [ML_W-1:0]   ml_wr;

    vrra_ram #(
        .WIDTH (OW),
        .DEPTH (SLOTS),
        .AW    (AW)
    ) u_ring (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .re    (ram_re),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    // Head of the region: oldest offset plus used bytes, modulo text size
    assign head_used = ts_reg - free_reg;
    assign head_sum  = HW'(ooff_reg) + HW'(head_used);
    assign head_c    = (head_sum >= HW'(ts_reg)) ? OW'(head_sum - HW'(ts_reg)) : OW'(head_sum);

    assign need_room = (free_reg < TS_W'(len_reg)) && (count_reg != '0);
    assign out_free  = !out_valid_reg || out_ready;

    // Next oldest slot
    assign oldest_inc  = (AW+1)'(oldest_reg) + (AW+1)'(1);
    assign oldest_wrap = (SW'(oldest_inc) == SW'(ml_reg)) ? '0 : AW'(oldest_inc);

    // Slot of a record by age, and slot after the newest record
    assign rd_sum  = SW'(oldest_reg) + SW'(idx_reg);
    assign rd_slot = (rd_sum >= SW'(ml_reg)) ? AW'(rd_sum - SW'(ml_reg)) : AW'(rd_sum);
    assign pl_sum  = SW'(oldest_reg) + SW'(count_reg);
    assign pl_slot = (pl_sum >= SW'(ml_reg)) ? AW'(pl_sum - SW'(ml_reg)) : AW'(pl_sum);

    // Bytes released by an eviction
    always_comb
    begin
        if (ram_rdata > ooff_reg)
        begin
            ev_add = TS_W'(ram_rdata - ooff_reg);
        end
        else if (ts_reg > TS_W'(ooff_reg))
        begin
            ev_add = ts_reg - TS_W'(ooff_reg);
        end
        else
        begin
            ev_add = '0;
        end
    end
    assign ev_sum = HW'(free_reg) + HW'(ev_add);

    // Register write clamping
    assign ts_wr = (cfg_data[TS_W-1:0] == '0) ? TS_W'(1) :
                   (cfg_data[TS_W-1:0] > TS_W'(TS_MAX)) ? TS_W'(TS_MAX) : cfg_data[TS_W-1:0];
    assign ml_wr = (cfg_data[ML_W-1:0] == '0) ? ML_W'(1) :
                   (cfg_data[ML_W-1:0] > ML_W'(SLOTS)) ? ML_W'(SLOTS) : cfg_data[ML_W-1:0];

    assign in_ready = (state_reg == S_IDLE);

    // Sequencer
    always_comb
    begin
        logic   do_evict;
        state_t ev_ret;

        do_evict       = 1'b0;
        ev_ret         = S_IDLE;
        state_next     = state_reg;
        ret_next       = ret_reg;
        ts_next        = ts_reg;
        ml_next        = ml_reg;
        oldest_next    = oldest_reg;
        count_next     = count_reg;
        free_next      = free_reg;
        ooff_next      = ooff_reg;
        out_valid_next = out_valid_reg && !out_ready;
        head_next      = head_c;
        kind_next      = kind_reg;
        len_next       = len_reg;
        idx_next       = idx_reg;
        evc_next       = evc_reg;
        status_next    = status_reg;
        offset_next    = offset_reg;
        evicted_next   = evicted_reg;
        lcount_next    = lcount_reg;
        ram_we         = 1'b0;
        ram_waddr      = pl_slot;
        ram_wdata      = head_reg;
        ram_re         = 1'b0;
        ram_raddr      = rd_slot;

        case (state_reg)
            S_IDLE:
            begin
                if (in_valid)
                begin
                    kind_next  = kind_t'(kind);
                    len_next   = (record_length == '0) ? LEN_W'(1) : record_length;
                    idx_next   = line_index;
                    evc_next   = '0;
                    state_next = S_START;
                end
            end
            S_START:
            begin
                if (kind_reg == KIND_READ)
                begin
                    if (CNT_W'(idx_reg) < count_reg)
                    begin
                        ram_re     = 1'b1;
                        ram_raddr  = rd_slot;
                        state_next = S_RDDATA;
                    end
                    else if (out_free)
                    begin
                        out_valid_next = 1'b1;
                        status_next    = ST_NO_RECORD;
                        offset_next    = '0;
                        evicted_next   = '0;
                        lcount_next    = count_reg;
                        state_next     = S_IDLE;
                    end
                end
                else if (TS_W'(len_reg) > ts_reg)
                begin
                    if (out_free)
                    begin
                        out_valid_next = 1'b1;
                        status_next    = ST_TOO_LONG;
                        offset_next    = '0;
                        evicted_next   = '0;
                        lcount_next    = count_reg;
                        state_next     = S_IDLE;
                    end
                end
                else if (count_reg >= CNT_W'(ml_reg))
                begin
                    do_evict = 1'b1;
                    ev_ret   = S_ROOM1;
                end
                else
                begin
                    state_next = S_ROOM1;
                end
            end
            S_ROOM1:
            begin
                if (need_room)
                begin
                    do_evict = 1'b1;
                    ev_ret   = S_ROOM1;
                end
                else
                begin
                    state_next = S_GAP;
                end
            end
            S_GAP:
            begin
                // Tail gap too short: count it as used
                if (HW'(head_reg) + HW'(len_reg) > HW'(ts_reg))
                begin
                    free_next = free_reg - (ts_reg - TS_W'(head_reg));
                end
                state_next = S_ROOM2;
            end
            S_ROOM2:
            begin
                if (need_room)
                begin
                    do_evict = 1'b1;
                    ev_ret   = S_ROOM2;
                end
                else
                begin
                    state_next = S_PLACE;
                end
            end
            S_PLACE:
            begin
                if (out_free)
                begin
                    ram_we         = 1'b1;
                    ram_waddr      = pl_slot;
                    ram_wdata      = head_reg;
                    count_next     = count_reg + CNT_W'(1);
                    free_next      = free_reg - TS_W'(len_reg);
                    out_valid_next = 1'b1;
                    status_next    = ST_OK;
                    offset_next    = OFF_W'(head_reg);
                    evicted_next   = evc_reg;
                    lcount_next    = count_reg + CNT_W'(1);
                    state_next     = S_IDLE;
                end
            end
            S_EVUPD:
            begin
                free_next  = (ev_sum > HW'(ts_reg)) ? ts_reg : TS_W'(ev_sum);
                ooff_next  = ram_rdata;
                state_next = ret_reg;
            end
            S_RDDATA:
            begin
                if (out_free)
                begin
                    out_valid_next = 1'b1;
                    status_next    = ST_OK;
                    offset_next    = OFF_W'(ram_rdata);
                    evicted_next   = '0;
                    lcount_next    = count_reg;
                    state_next     = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase

        // Evict the oldest record; fetch the next oldest offset unless empty
        if (do_evict)
        begin
            evc_next = evc_reg + EVC_W'(1);
            if (count_reg == CNT_W'(1))
            begin
                count_next  = '0;
                oldest_next = '0;
                ooff_next   = '0;
                free_next   = ts_reg;
                state_next  = ev_ret;
            end
            else
            begin
                count_next  = count_reg - CNT_W'(1);
                oldest_next = oldest_wrap;
                ram_re      = 1'b1;
                ram_raddr   = oldest_wrap;
                ret_next    = ev_ret;
                state_next  = S_EVUPD;
            end
        end

        // Register writes clear the store
        if (cfg_we)
        begin
            case (cfg_index)
                CFG_TEXT_SIZE:
                begin
                    ts_next     = ts_wr;
                    free_next   = ts_wr;
                    count_next  = '0;
                    oldest_next = '0;
                    ooff_next   = '0;
                end
                CFG_MAX_LINES:
                begin
                    ml_next     = ml_wr;
                    free_next   = ts_reg;
                    count_next  = '0;
                    oldest_next = '0;
                    ooff_next   = '0;
                end
                default:
                begin
                end
            endcase
        end
    end

    // Control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            ret_reg       <= S_IDLE;
            ts_reg        <= TS_W'(TS_RST);
            ml_reg        <= ML_W'(ML_RST);
            oldest_reg    <= '0;
            count_reg     <= '0;
            free_reg      <= TS_W'(TS_RST);
            ooff_reg      <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            ret_reg       <= ret_next;
            ts_reg        <= ts_next;
            ml_reg        <= ml_next;
            oldest_reg    <= oldest_next;
            count_reg     <= count_next;
            free_reg      <= free_next;
            ooff_reg      <= ooff_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // Payload registers
    always_ff @(posedge clk)
    begin
        head_reg    <= head_next;
        kind_reg    <= kind_next;
        len_reg     <= len_next;
        idx_reg     <= idx_next;
        evc_reg     <= evc_next;
        status_reg  <= status_next;
        offset_reg  <= offset_next;
        evicted_reg <= evicted_next;
        lcount_reg  <= lcount_next;
    end

    assign out_valid  = out_valid_reg;
    assign status     = status_reg;
    assign offset     = offset_reg;
    assign evicted    = evicted_reg;
    assign line_count = lcount_reg;

endmodule

// ----- design/vrra_checker.sv -----
module vrra_checker (
    input logic                           clk,
    input logic                           rst_n,
    input logic                           in_valid,
    input logic                           in_ready,
    input logic                           out_valid,
    input logic                           out_ready,
    input logic [vrra_pkg::STAT_W-1:0]    status,
    input logic [vrra_pkg::OFF_W-1:0]     offset,
    input logic [vrra_pkg::EVC_W-1:0]     evicted,
    input logic [vrra_pkg::CNT_W-1:0]     line_count
);

    import vrra_pkg::*;

    // A stalled result holds
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(status) && $stable(offset)
            && $stable(evicted) && $stable(line_count))
        else $error("result changed while stalled");

    // One request at a time: busy right after an accept
    a_busy: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && in_ready |=> !in_ready)
        else $error("request accepted while busy");

    // Error results carry no offset and no evictions
    a_err_zero: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && (status == ST_TOO_LONG || status == ST_NO_RECORD)
            |-> offset == '0 && evicted == '0)
        else $error("error result with nonzero offset or eviction count");

    // A successful request always leaves at least one record stored
    a_ok_count: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && status == ST_OK |-> line_count != '0)
        else $error("successful result with empty store");

endmodule

bind variable_record_ring_allocator_unit vrra_checker u_vrra_checker (.*);

// ----- tb/tb.sv -----
`timescale 1ns / 100ps

module tb;

    import vrra_pkg::*;

    localparam int STALL_LIMIT = 4000;
    localparam int IDLE_PCT    = 37;

    typedef struct packed {
        kind_t              op;
        logic [LEN_W-1:0]   len;
        logic [IDX_W-1:0]   idx;
    } request_t;

    typedef struct packed {
        status_t            st;
        logic [OFF_W-1:0]   off;
        logic [EVC_W-1:0]   ev;
        logic [CNT_W-1:0]   cnt;
    } alloc_result_t;

    logic                  clk = 1'b0;
    logic                  rst_n = 1'b0;
    logic                  cfg_we = 1'b0;
    logic [CFG_IDX_W-1:0]  cfg_index = '0;
    logic [CFG_W-1:0]      cfg_data = '0;
    logic                  in_valid = 1'b0;
    logic                  in_ready;
    logic                  kind = 1'b0;
    logic [LEN_W-1:0]      record_length = '0;
    logic [IDX_W-1:0]      line_index = '0;
    logic                  out_valid;
    logic                  out_ready = 1'b0;
    logic [STAT_W-1:0]     status;
    logic [OFF_W-1:0]      offset;
    logic [EVC_W-1:0]      evicted;
    logic [CNT_W-1:0]      line_count;

    variable_record_ring_allocator_unit dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .cfg_we       (cfg_we),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data),
        .in_valid     (in_valid),
        .in_ready     (in_ready),
        .kind         (kind),
        .record_length(record_length),
        .line_index   (line_index),
        .out_valid    (out_valid),
        .out_ready    (out_ready),
        .status       (status),
        .offset       (offset),
        .evicted      (evicted),
        .line_count   (line_count)
    );

    // Requests waiting to be sent and results predicted for accepted requests
    request_t      queued_requests[$];
    alloc_result_t alloc_results[$];
    request_t      live_request;
    alloc_result_t due_result;
    int            mismatches = 0;
    int            quiet_cycles = 0;
    bit            steady = 1'b0;

    // Shadow of the allocator: offset ring, oldest slot, record count, free bytes
    int unsigned ring_off [LINE_SLOTS_DEF];
    int unsigned ring_oldest;
    int unsigned ring_count;
    int unsigned ring_free;
    int unsigned cur_text;
    int unsigned cur_lines;

    function automatic void clear_ring();
        foreach (ring_off[i])
            ring_off[i] = 0;
        ring_oldest = 0;
        ring_count  = 0;
        ring_free   = cur_text;
    endfunction

    // Drop the oldest record and give back the bytes up to the next one
    function automatic void drop_oldest();
        int unsigned prev_off;
        int unsigned next_off;
        prev_off = ring_off[ring_oldest % LINE_SLOTS_DEF];
        ring_count--;
        if (ring_count == 0)
        begin
            ring_oldest = 0;
            ring_off[0] = 0;
            ring_free   = cur_text;
            return;
        end
        ring_oldest++;
        if (ring_oldest >= cur_lines)
            ring_oldest = 0;
        next_off = ring_off[ring_oldest % LINE_SLOTS_DEF];
        if (next_off > prev_off)
            ring_free += next_off - prev_off;
        else if (cur_text > prev_off)
            ring_free += cur_text - prev_off;
        if (ring_free > cur_text)
            ring_free = cur_text;
    endfunction

    function automatic void make_room(int unsigned len);
        while (ring_free < len && ring_count > 0)
            drop_oldest();
    endfunction

    function automatic int unsigned head_pos();
        int unsigned h;
        h = ring_off[ring_oldest % LINE_SLOTS_DEF] + (cur_text - ring_free);
        while (h >= cur_text)
            h -= cur_text;
        return h;
    endfunction

    // Expected result of one request; updates the shadow state
    function automatic alloc_result_t serve_request(request_t rq);
        alloc_result_t res;
        int unsigned   len;
        int unsigned   slot;
        int unsigned   head;
        int unsigned   before_count;
        res = '{ST_OK, '0, '0, '0};
        if (rq.op == KIND_READ)
        begin
            if (rq.idx < ring_count)
            begin
                slot = ring_oldest + rq.idx;
                if (slot >= cur_lines)
                    slot -= cur_lines;
                res.off = OFF_W'(ring_off[slot % LINE_SLOTS_DEF]);
            end
            else
                res.st = ST_NO_RECORD;
        end
        else
        begin
            len = (rq.len == 0) ? 1 : 32'(rq.len);
            if (len > cur_text)
                res.st = ST_TOO_LONG;
            else
            begin
                before_count = ring_count;
                if (ring_count >= cur_lines)
                    drop_oldest();
                make_room(len);
                // tail gap too short: skip it and count it as used
                head = head_pos();
                if (head + len > cur_text)
                    ring_free -= cur_text - head;
                make_room(len);
                head = head_pos();
                res.ev = EVC_W'(before_count - ring_count);
                slot = ring_oldest + ring_count;
                if (slot >= cur_lines)
                    slot -= cur_lines;
                ring_off[slot % LINE_SLOTS_DEF] = head;
                ring_count++;
                ring_free -= len;
                res.off = OFF_W'(head);
            end
        end
        res.cnt = CNT_W'(ring_count);
        return res;
    endfunction

    function automatic request_t random_request(int unsigned lmax, int unsigned read_pct,
                                                int unsigned idx_max);
        request_t    rq;
        int unsigned pick;
        rq.len = LEN_W'($urandom_range(0, 8191));
        rq.idx = IDX_W'($urandom_range(0, 255));
        if ($urandom_range(0, 99) < read_pct)
        begin
            rq.op = KIND_READ;
            if ($urandom_range(0, 99) < 75)
                rq.idx = IDX_W'($urandom_range(0, idx_max));
        end
        else
        begin
            rq.op = KIND_ADD;
            pick  = $urandom_range(0, 99);
            if (pick < 4)
                rq.len = '0;
            else if (pick < 9)
                rq.len = LEN_W'($urandom_range(0, 8191));
            else if (pick < 13)
                rq.len = LEN_W'(cur_text);
            else
                rq.len = LEN_W'($urandom_range(1, lmax));
        end
        return rq;
    endfunction

    task automatic push_add(input int unsigned len);
        queued_requests = {queued_requests, request_t'{KIND_ADD, LEN_W'(len), '0}};
    endtask

    task automatic push_read(input int unsigned idx);
        queued_requests = {queued_requests, request_t'{KIND_READ, '0, IDX_W'(idx)}};
    endtask

    // Register write; both registers clear the store
    task automatic write_reg(input cfg_index_t idx, input logic [CFG_W-1:0] data);
        int unsigned v;
        @(posedge clk);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= data;
        @(posedge clk);
        cfg_we    <= 1'b0;
        if (idx == CFG_TEXT_SIZE)
        begin
            v = 32'(data[TS_W-1:0]);
            if (v == 0)
                v = 1;
            if (v > TEXT_BYTES_DEF)
                v = TEXT_BYTES_DEF;
            cur_text = v;
        end
        else
        begin
            v = 32'(data[ML_W-1:0]);
            if (v == 0)
                v = 1;
            if (v > LINE_SLOTS_DEF)
                v = LINE_SLOTS_DEF;
            cur_lines = v;
        end
        clear_ring();
    endtask

    // Hold off until every request has been answered, then let the sequencer settle
    task automatic settle();
        while (queued_requests.size() != 0 || in_valid || alloc_results.size() != 0)
            @(negedge clk);
        repeat (8) @(posedge clk);
    endtask

    task automatic run_phase(input logic [CFG_W-1:0] ts_raw, input logic [CFG_W-1:0] ml_raw,
                             input int n, input int unsigned lmax,
                             input int unsigned read_pct, input bit calm);
        int unsigned idx_max;
        settle();
        write_reg(CFG_TEXT_SIZE, ts_raw);
        write_reg(CFG_MAX_LINES, ml_raw);
        steady  = calm;
        idx_max = (cur_lines > 255) ? 255 : cur_lines;
        for (int i = 0; i < n; i++)
            queued_requests = {queued_requests, random_request(lmax, read_pct, idx_max)};
    endtask

    // Clock
    initial
    begin
        forever #4 clk = ~clk;
    end

    // Request driver
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid      <= 1'b0;
            kind          <= 1'b0;
            record_length <= '0;
            line_index    <= '0;
        end
        else
        begin
            if (in_valid && in_ready)
                alloc_results = {alloc_results, serve_request(live_request)};
            if (!in_valid || in_ready)
            begin
                if (queued_requests.size() != 0 &&
                    (steady || $urandom_range(0, 99) >= IDLE_PCT))
                begin
                    live_request   = queued_requests.pop_front();
                    in_valid      <= 1'b1;
                    kind          <= live_request.op;
                    record_length <= live_request.len;
                    line_index    <= live_request.idx;
                end
                else
                    in_valid <= 1'b0;
            end
        end
    end

    // Result monitor
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_ready <= 1'b0;
        else
        begin
            out_ready <= steady || ($urandom_range(0, 99) >= IDLE_PCT);
            if (out_valid && out_ready)
            begin
                if (alloc_results.size() == 0)
                begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("unexpected result: status %0d offset %0d evicted %0d count %0d",
                                 status, offset, evicted, line_count);
                end
                else
                begin
                    due_result = alloc_results.pop_front();
                    if (status !== due_result.st || offset !== due_result.off ||
                        evicted !== due_result.ev || line_count !== due_result.cnt)
                    begin
                        mismatches++;
                        if (mismatches <= 10)
                            $display({"mismatch: status %0d/%0d offset %0d/%0d ",
                                      "evicted %0d/%0d count %0d/%0d (exp/got)"},
                                     due_result.st, status, due_result.off, offset,
                                     due_result.ev, evicted, due_result.cnt, line_count);
                    end
                end
            end
        end
    end

    // Watchdog on cycles with no handshake on either channel
    always @(posedge clk)
    begin
        if ((in_valid && in_ready) || (out_valid && out_ready))
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles >= STALL_LIMIT)
        begin
            $display("Verification failed");
            $finish;
        end
    end

    // Stimulus
    initial
    begin
        cur_text  = TEXT_BYTES_DEF;
        cur_lines = LINE_SLOTS_DEF;
        clear_ring();
        repeat (3) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // directed: empty reads, zero and oversize lengths, full-region adds, tail skip
        push_read(0);
        push_read(255);
        push_add(0);
        push_add(4097);
        push_add(8191);
        push_add(4096);
        push_add(1);
        push_add(2000);
        push_add(2000);
        push_add(200);
        push_read(0);
        push_read(1);
        push_read(2);
        push_add(4096);
        push_add(8);
        push_add(4095);
        push_add(4096);
        push_add(13'h1001);
        push_read(128);
        push_add(1);
        push_add(1);
        push_read(1);

        run_phase(13'd100, 13'd8, 250, 40, 30, 1'b0);
        run_phase(13'd0, 13'd3, 80, 2, 30, 1'b0);
        run_phase(13'd8191, 13'd0, 80, 4096, 30, 1'b0);

        // fill all 256 slots, overflow the ring, then wipe it with one region-sized add
        run_phase(13'd4096, 13'h1FFF, 150, 16, 15, 1'b0);
        for (int i = 0; i < 260; i++)
            push_add($urandom_range(1, 15));
        push_read(255);
        push_read(0);
        push_add(4096);

        run_phase(13'd37, 13'd200, 250, 20, 30, 1'b0);
        run_phase(13'd1000, 13'd16, 250, 300, 30, 1'b1);
        run_phase(13'd4095, 13'd256, 120, 4095, 25, 1'b0);
        run_phase(13'd2, 13'd2, 80, 3, 30, 1'b0);
        run_phase(13'd4097, 13'd257, 60, 300, 30, 1'b0);

        settle();
        repeat (20) @(posedge clk);
        if (mismatches == 0 && alloc_results.size() == 0)
            $display("Verification passed");
        else
            $display("Verification failed");
        $finish;
    end

endmodule
